[rtl/core/cstt_pkg.sv]
package cstt_pkg;

    localparam int AXES        = 3;
    localparam int SQRT_STAGES = 33;   // one root bit per stage
    localparam int QUO_BITS    = 32;   // quotient bits, one per stage
    localparam int DIV_STAGES  = QUO_BITS + 2;
    localparam int LATENCY     = 2 + 1 + SQRT_STAGES + DIV_STAGES;

    typedef logic signed [31:0] coord_t;
    typedef logic [30:0]        cfg_val_t;

    localparam logic [0:0] CFG_STEP  = 1'b0;
    localparam logic [0:0] CFG_REACH = 1'b1;

    localparam cfg_val_t STEP_RESET  = 31'd131072;
    localparam cfg_val_t REACH_RESET = 31'd13107;

    typedef struct packed {
        coord_t [AXES-1:0]      pos;
        coord_t [AXES-1:0]      goal;
        logic [AXES-1:0][63:0]  prod;
        logic [AXES-1:0]        neg;
        logic                   near_reach;
        logic                   near_step;
    } carry_t;

    typedef struct packed {
        coord_t next_x;
        coord_t next_y;
        coord_t next_z;
        logic   reached;
    } result_t;

endpackage

[rtl/core/cstt_front.sv]
module cstt_front (
    input  logic            clk,
    input  logic            en,
    input  cstt_pkg::coord_t pos,
    input  cstt_pkg::coord_t goal,
    input  cstt_pkg::cfg_val_t step,
    output logic [64:0]     sq,
    output logic [63:0]     prod,
    output logic            neg
);

    logic signed [32:0] diff_reg;
    logic [32:0]        mag;
    logic [64:0]        sq_reg;
    logic [63:0]        prod_reg;
    logic               neg_reg;

    assign mag = diff_reg[32] ? 33'(-diff_reg) : 33'(diff_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg <= {goal[31], goal} - {pos[31], pos};
            sq_reg   <= {32'd0, mag} * {32'd0, mag};
            prod_reg <= {31'd0, mag} * {33'd0, step};
            neg_reg  <= diff_reg[32];
        end
    end

    assign sq   = sq_reg;
    assign prod = prod_reg;
    assign neg  = neg_reg;

endmodule

[rtl/core/cstt_sqrt.sv]
module cstt_sqrt (
    input  logic              clk,
    input  logic              en,
    input  logic [65:0]       radicand,
    input  cstt_pkg::carry_t  carry_in,
    output logic [32:0]       root,
    output cstt_pkg::carry_t  carry_out
);

    logic [35:0]      rem_reg   [cstt_pkg::SQRT_STAGES];
    logic [32:0]      root_reg  [cstt_pkg::SQRT_STAGES];
    logic [65:0]      val_reg   [cstt_pkg::SQRT_STAGES];
    cstt_pkg::carry_t carry_reg [cstt_pkg::SQRT_STAGES];

    for (genvar s = 0; s < cstt_pkg::SQRT_STAGES; s++)
    begin : g_stage
        logic [35:0]      rem_in;
        logic [32:0]      root_in;
        logic [65:0]      val_in;
        cstt_pkg::carry_t c_in;
        logic [35:0]      r4;
        logic [35:0]      trial;
        logic             ge;

        if (s == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign val_in  = radicand;
            assign c_in    = carry_in;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign val_in  = val_reg[s-1];
            assign c_in    = carry_reg[s-1];
        end

        // bring down the next bit pair and try the trial subtrahend
        assign r4    = {rem_in[33:0], val_in[65:64]};
        assign trial = {1'b0, root_in, 2'b01};
        assign ge    = r4 >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]   <= ge ? r4 - trial : r4;
                root_reg[s]  <= {root_in[31:0], ge};
                val_reg[s]   <= {val_in[63:0], 2'b00};
                carry_reg[s] <= c_in;
            end
        end
    end

    assign root      = root_reg[cstt_pkg::SQRT_STAGES-1];
    assign carry_out = carry_reg[cstt_pkg::SQRT_STAGES-1];

endmodule

[rtl/core/cstt_div.sv]
module cstt_div (
    input  logic             clk,
    input  logic             en,
    input  logic [63:0]      prod,
    input  logic [32:0]      divisor,
    input  cstt_pkg::coord_t pos,
    input  logic             neg,
    output cstt_pkg::coord_t next
);

    localparam int N = cstt_pkg::QUO_BITS + 1;

    logic [32:0]      rem_reg  [N];
    logic [31:0]      low_reg  [N];
    logic [31:0]      quo_reg  [N];
    logic [32:0]      dist_reg [N];
    cstt_pkg::coord_t pos_reg  [N];
    logic             neg_reg  [N];
    logic [63:0]      num;
    cstt_pkg::coord_t next_reg;
    logic signed [33:0] moved;

    // numerator with half the divisor added for round to nearest
    assign num = prod + {32'd0, divisor[32:1]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= {1'b0, num[63:32]};
            low_reg[0]  <= num[31:0];
            quo_reg[0]  <= '0;
            dist_reg[0] <= divisor;
            pos_reg[0]  <= pos;
            neg_reg[0]  <= neg;
        end
    end

    for (genvar k = 1; k < N; k++)
    begin : g_stage
        logic [33:0] r2;
        logic        ge;

        assign r2 = {rem_reg[k-1], low_reg[k-1][31]};
        assign ge = r2 >= {1'b0, dist_reg[k-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? 33'(r2 - {1'b0, dist_reg[k-1]}) : r2[32:0];
                low_reg[k]  <= {low_reg[k-1][30:0], 1'b0};
                quo_reg[k]  <= {quo_reg[k-1][30:0], ge};
                dist_reg[k] <= dist_reg[k-1];
                pos_reg[k]  <= pos_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
            end
        end
    end

    assign moved = neg_reg[N-1]
        ? {{2{pos_reg[N-1][31]}}, pos_reg[N-1]} - {2'b00, quo_reg[N-1]}
        : {{2{pos_reg[N-1][31]}}, pos_reg[N-1]} + {2'b00, quo_reg[N-1]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (dist_reg[N-1] == '0)
                next_reg <= pos_reg[N-1];
            else if (moved > 34'sh7FFFFFFF)
                next_reg <= 32'sh7FFFFFFF;
            else if (moved < -34'sh80000000)
                next_reg <= 32'sh80000000;
            else
                next_reg <= moved[31:0];
        end
    end

    assign next = next_reg;

endmodule

[rtl/core/clamped_step_toward_target.sv]
// Clamped step toward a target point, signed Q16.16 metres.
//
// Input channel (in_valid / in_ready): one beat carries the current
// position pos_x/y/z and the target goal_x/y/z. Output channel
// (out_valid / out_ready): one beat carries the next setpoint
// next_x/y/z and the reached flag. Every input beat gives one output beat.
//
// Throughput: one beat per cycle while the output buffer has room. Three
// axis lanes work side by side; a shared 33-stage square root pipeline
// (one root bit per stage) and a 34-stage divider in each lane (one
// quotient bit per inner stage) set the depth.
//
// Configuration: cfg_we writes cfg_wdata into step_length (index 0) or
// reach_threshold (index 1). Write only while the block is idle.
// Reset clears the pipeline and the output buffer and loads the default
// step length (2.0) and reach threshold (about 0.2).
// Stall: a two-entry output buffer decouples the sides; the pipeline holds
// as a whole while the buffer is full, and in_ready drops then.
module clamped_step_toward_target (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  cstt_pkg::coord_t  pos_x,
    input  cstt_pkg::coord_t  pos_y,
    input  cstt_pkg::coord_t  pos_z,
    input  cstt_pkg::coord_t  goal_x,
    input  cstt_pkg::coord_t  goal_y,
    input  cstt_pkg::coord_t  goal_z,
    output logic              out_valid,
    input  logic              out_ready,
    output cstt_pkg::coord_t  next_x,
    output cstt_pkg::coord_t  next_y,
    output cstt_pkg::coord_t  next_z,
    output logic              reached,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_addr,
    input  logic [30:0]       cfg_wdata
);

    typedef struct packed {
        cstt_pkg::coord_t [cstt_pkg::AXES-1:0] goal;
        logic near_reach;
        logic near_step;
    } tail_t;

    cstt_pkg::cfg_val_t step_reg;
    cstt_pkg::cfg_val_t reach_reg;
    logic [61:0]        step_sq_reg;
    logic [61:0]        reach_sq_reg;

    logic                   en;
    logic [cstt_pkg::LATENCY-1:0] vld_reg;

    cstt_pkg::coord_t pos_in  [cstt_pkg::AXES];
    cstt_pkg::coord_t goal_in [cstt_pkg::AXES];
    cstt_pkg::coord_t pos_d_reg  [2][cstt_pkg::AXES];
    cstt_pkg::coord_t goal_d_reg [2][cstt_pkg::AXES];

    logic [64:0] lane_sq   [cstt_pkg::AXES];
    logic [63:0] lane_prod [cstt_pkg::AXES];
    logic        lane_neg  [cstt_pkg::AXES];

    logic [65:0]       sum_reg;
    cstt_pkg::carry_t  merge_reg;
    cstt_pkg::carry_t  sqrt_in;
    cstt_pkg::carry_t  sqrt_out;
    logic [32:0]       dist_root;

    cstt_pkg::coord_t  lane_next [cstt_pkg::AXES];
    tail_t             tail_reg  [cstt_pkg::DIV_STAGES];
    tail_t             tail_last;
    cstt_pkg::result_t res;

    cstt_pkg::result_t buf_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        cnt_reg;
    logic              push;
    logic              pop;

    // configuration registers and their squares for the distance tests
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg     <= cstt_pkg::STEP_RESET;
            reach_reg    <= cstt_pkg::REACH_RESET;
            step_sq_reg  <= 62'd17179869184;
            reach_sq_reg <= 62'd171793449;
        end
        else
        begin
            if (cfg_we && cfg_addr == cstt_pkg::CFG_STEP)
                step_reg <= cfg_wdata;
            if (cfg_we && cfg_addr == cstt_pkg::CFG_REACH)
                reach_reg <= cfg_wdata;
            step_sq_reg  <= step_reg * step_reg;
            reach_sq_reg <= reach_reg * reach_reg;
        end
    end

    // advance the whole pipeline while the output buffer has room
    assign en       = cnt_reg != 2'd2;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[cstt_pkg::LATENCY-2:0], in_valid};
    end

    assign pos_in[0]  = pos_x;
    assign pos_in[1]  = pos_y;
    assign pos_in[2]  = pos_z;
    assign goal_in[0] = goal_x;
    assign goal_in[1] = goal_y;
    assign goal_in[2] = goal_z;

    // per-axis difference, square and step product
    for (genvar i = 0; i < cstt_pkg::AXES; i++)
    begin : g_front
        cstt_front u_front (
            .clk  (clk),
            .en   (en),
            .pos  (pos_in[i]),
            .goal (goal_in[i]),
            .step (step_reg),
            .sq   (lane_sq[i]),
            .prod (lane_prod[i]),
            .neg  (lane_neg[i])
        );

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pos_d_reg[0][i]  <= pos_in[i];
                pos_d_reg[1][i]  <= pos_d_reg[0][i];
                goal_d_reg[0][i] <= goal_in[i];
                goal_d_reg[1][i] <= goal_d_reg[0][i];
            end
        end
    end

    // merge the lanes: full-width squared distance
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= {1'b0, lane_sq[0]} + {1'b0, lane_sq[1]} + {1'b0, lane_sq[2]};
            for (int i = 0; i < cstt_pkg::AXES; i++)
            begin
                merge_reg.pos[i]  <= pos_d_reg[1][i];
                merge_reg.goal[i] <= goal_d_reg[1][i];
                merge_reg.prod[i] <= lane_prod[i];
                merge_reg.neg[i]  <= lane_neg[i];
            end
            merge_reg.near_reach <= 1'b0;
            merge_reg.near_step  <= 1'b0;
        end
    end

    // exact tests against the squared thresholds
    always_comb
    begin
        sqrt_in            = merge_reg;
        sqrt_in.near_reach = sum_reg < {4'd0, reach_sq_reg};
        sqrt_in.near_step  = sum_reg < {4'd0, step_sq_reg};
    end

    cstt_sqrt u_sqrt (
        .clk       (clk),
        .en        (en),
        .radicand  (sum_reg),
        .carry_in  (sqrt_in),
        .root      (dist_root),
        .carry_out (sqrt_out)
    );

    for (genvar i = 0; i < cstt_pkg::AXES; i++)
    begin : g_div
        cstt_div u_div (
            .clk     (clk),
            .en      (en),
            .prod    (sqrt_out.prod[i]),
            .divisor (dist_root),
            .pos     (sqrt_out.pos[i]),
            .neg     (sqrt_out.neg[i]),
            .next    (lane_next[i])
        );
    end

    // hold the target and the test outcome alongside the dividers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tail_reg[0].goal       <= sqrt_out.goal;
            tail_reg[0].near_reach <= sqrt_out.near_reach;
            tail_reg[0].near_step  <= sqrt_out.near_step;
            for (int k = 1; k < cstt_pkg::DIV_STAGES; k++)
                tail_reg[k] <= tail_reg[k-1];
        end
    end

    assign tail_last = tail_reg[cstt_pkg::DIV_STAGES-1];

    always_comb
    begin
        if (tail_last.near_reach || tail_last.near_step)
        begin
            res.next_x = tail_last.goal[0];
            res.next_y = tail_last.goal[1];
            res.next_z = tail_last.goal[2];
        end
        else
        begin
            res.next_x = lane_next[0];
            res.next_y = lane_next[1];
            res.next_z = lane_next[2];
        end
        res.reached = tail_last.near_reach;
    end

    // two-entry output buffer
    assign push = en && vld_reg[cstt_pkg::LATENCY-1];
    assign pop  = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wr_ptr_reg] <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= 2'(cnt_reg + {1'b0, push} - {1'b0, pop});
        end
    end

    assign out_valid = cnt_reg != 2'd0;
    assign next_x    = buf_reg[rd_ptr_reg].next_x;
    assign next_y    = buf_reg[rd_ptr_reg].next_y;
    assign next_z    = buf_reg[rd_ptr_reg].next_z;
    assign reached   = buf_reg[rd_ptr_reg].reached;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_stall_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result waiting");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> vld_reg[0])
        else $error("accepted beat did not enter the pipeline");
`endif

endmodule
